// ----- rtl/core/source_byte_tokenizer_macros.svh -----
// Assertion macros for the source byte tokenizer.
// Needs clk and rst_n in the scope of each use.
`ifndef SOURCE_BYTE_TOKENIZER_MACROS_SVH
`define SOURCE_BYTE_TOKENIZER_MACROS_SVH

`ifndef SYNTHESIS
`define SBT_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tokenizer assertion failed");
`define SBT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tokenizer assertion failed");
`else
`define SBT_ASSERT_SAME(lbl, ante, cons)
`define SBT_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ----- rtl/core/sbt_pkg.sv -----
// Shared types, token codes and keyword/character tables for the tokenizer.
// No dependencies.
package sbt_pkg;

  localparam int LEN_LIMIT = 63;
  localparam int LEN_BITS  = $clog2(LEN_LIMIT + 1);
  localparam int POS_BITS  = 32;
  localparam int LINE_BITS = 24;
  localparam int COL_BITS  = 16;
  localparam int PREFIX_CHARS = 6;
  localparam int NUM_KW = 19;

  localparam logic [1:0] MODE_IDLE   = 2'd0;
  localparam logic [1:0] MODE_IDENT  = 2'd1;
  localparam logic [1:0] MODE_NUMBER = 2'd2;
  localparam logic [1:0] MODE_COLON  = 2'd3;

  localparam logic [5:0] TT_EOF        = 6'd0;
  localparam logic [5:0] TT_IDENT      = 6'd1;
  localparam logic [5:0] TT_NUMBER     = 6'd2;
  localparam logic [5:0] TT_KW_BASE    = 6'd3;
  localparam logic [5:0] TT_ASSIGN     = 6'd22;
  localparam logic [5:0] TT_SEMI       = 6'd23;
  localparam logic [5:0] TT_COLON      = 6'd24;
  localparam logic [5:0] TT_COLONCOLON = 6'd25;
  localparam logic [5:0] TT_LBRACE     = 6'd26;
  localparam logic [5:0] TT_RBRACE     = 6'd27;
  localparam logic [5:0] TT_LPAREN     = 6'd28;
  localparam logic [5:0] TT_RPAREN     = 6'd29;
  localparam logic [5:0] TT_COMMA      = 6'd30;
  localparam logic [5:0] TT_PLUS       = 6'd31;
  localparam logic [5:0] TT_MINUS      = 6'd32;
  localparam logic [5:0] TT_STAR       = 6'd33;
  localparam logic [5:0] TT_SLASH      = 6'd34;
  localparam logic [5:0] TT_AMP        = 6'd35;
  localparam logic [5:0] TT_BANG       = 6'd36;
  localparam logic [5:0] TT_LBRACKET   = 6'd37;
  localparam logic [5:0] TT_RBRACKET   = 6'd38;
  localparam logic [5:0] TT_DOT        = 6'd39;
  localparam logic [5:0] TT_UNKNOWN    = 6'd40;

  localparam logic [7:0] CH_NEWLINE = 8'h0a;
  localparam logic [7:0] CH_UNDER   = 8'h5f;
  localparam logic [7:0] CH_DOT     = 8'h2e;
  localparam logic [7:0] CH_COLON   = 8'h3a;

  // keyword text, first byte in the low bits, zero padded
  localparam logic [47:0] KW_TEXT [NUM_KW] = '{
    48'h3869,         48'h363169,       48'h323369,       48'h343669,
    48'h3875,         48'h363175,       48'h323375,       48'h343675,
    48'h323366,       48'h343666,       48'h6c6f6f62,     48'h64696f76,
    48'h746375727473, 48'h6e66,         48'h65757274,     48'h65736c6166,
    48'h74736e6f63,   48'h6e7275746572, 48'h6d756e65
  };
  localparam int KW_LEN [NUM_KW] = '{
    2, 3, 3, 3, 2, 3, 3, 3, 3, 3, 4, 4, 6, 2, 4, 5, 5, 6, 4
  };

  typedef struct packed {
    logic [5:0]  token_type;
    logic [31:0] end_position;
    logic [23:0] line_number;
    logic [15:0] column_number;
    logic [5:0]  token_length;
    logic [7:0]  unknown_byte;
    logic        too_long;
    logic        last_of_run;
  } res_t;

  function automatic logic is_alpha(input logic [7:0] c);
    return c inside {[8'h61:8'h7a], [8'h41:8'h5a]};
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c inside {[8'h30:8'h39]};
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c inside {8'h20, [8'h09:8'h0d]};
  endfunction

  function automatic logic [5:0] ident_type(input logic [47:0] prefix,
                                            input logic [LEN_BITS-1:0] len,
                                            input logic ovf);
    logic [5:0] t;
    t = TT_IDENT;
    for (int k = 0; k < NUM_KW; k++) begin
      if (!ovf && prefix == KW_TEXT[k] && len == LEN_BITS'(KW_LEN[k])) begin
        t = 6'(TT_KW_BASE + 6'(k));
      end
    end
    return t;
  endfunction

  // TT_UNKNOWN for anything that is not a single-character token
  function automatic logic [5:0] punct_type(input logic [7:0] c);
    logic [5:0] t;
    case (c)
      8'h3d:   t = TT_ASSIGN;
      8'h3b:   t = TT_SEMI;
      8'h7b:   t = TT_LBRACE;
      8'h7d:   t = TT_RBRACE;
      8'h28:   t = TT_LPAREN;
      8'h29:   t = TT_RPAREN;
      8'h2c:   t = TT_COMMA;
      8'h2b:   t = TT_PLUS;
      8'h2d:   t = TT_MINUS;
      8'h2a:   t = TT_STAR;
      8'h2f:   t = TT_SLASH;
      8'h26:   t = TT_AMP;
      8'h21:   t = TT_BANG;
      8'h5b:   t = TT_LBRACKET;
      8'h5d:   t = TT_RBRACKET;
      8'h2e:   t = TT_DOT;
      default: t = TT_UNKNOWN;
    endcase
    return t;
  endfunction

endpackage

// ----- rtl/core/sbt_stream_if.sv -----
// Valid/ready channels for the tokenizer: byte words in, token words out.
// No dependencies; the token word fields follow sbt_pkg::res_t.
interface sbt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       end_of_input;

  modport source (output valid, ch, end_of_input, input ready);
  modport sink   (input valid, ch, end_of_input, output ready);
endinterface

interface sbt_out_if;
  logic        valid;
  logic        ready;
  logic [5:0]  token_type;
  logic [31:0] end_position;
  logic [23:0] line_number;
  logic [15:0] column_number;
  logic [5:0]  token_length;
  logic [7:0]  unknown_byte;
  logic        too_long;
  logic        last_of_run;

  modport source (output valid, token_type, end_position, line_number, column_number,
                  token_length, unknown_byte, too_long, last_of_run, input ready);
  modport sink   (input valid, token_type, end_position, line_number, column_number,
                  token_length, unknown_byte, too_long, last_of_run, output ready);
endinterface

// ----- rtl/core/source_byte_tokenizer.sv -----
// Streaming source tokenizer: one byte word in, up to two token words out.
// Depends on sbt_pkg, sbt_stream_if and source_byte_tokenizer_macros.svh.
//
// Takes one source byte word per cycle while in_chan.ready is high. Scan state
// and the token words for a byte are formed in the same cycle and land in a
// three-word output queue; in_chan.ready is high while at most one word is
// queued. A byte that ends a pending token and then forms a token of its own
// gives two words, which leave the queue one at a time, so the sustained rate
// is one byte per cycle when each byte gives at most one token and the sink
// takes a word every cycle. No clearing pass after reset.
`include "source_byte_tokenizer_macros.svh"

module source_byte_tokenizer (
  input  logic         clk,
  input  logic         rst_n,
  sbt_in_if.sink       in_chan,
  sbt_out_if.source    out_chan
);
  import sbt_pkg::*;

  logic [1:0]           mode_r, mode_nxt;
  logic                 seen_dot_r, seen_dot_nxt;
  logic [47:0]          prefix_r, prefix_nxt;
  logic [LEN_BITS-1:0]  len_r, len_nxt;
  logic                 ovf_r, ovf_nxt;
  logic [POS_BITS-1:0]  pos_r, pos_nxt;
  logic [LINE_BITS-1:0] line_r, line_nxt;
  logic [COL_BITS-1:0]  col_r, col_nxt;

  res_t       q_r [3];
  res_t       q_nxt [3];
  res_t       sh [3];
  logic [1:0] cnt_r, cnt_nxt;

  logic [7:0] c;
  logic       acc, pop, endf, a_c, d_c, s_c, col_c, dot_c;
  logic       cont, cc, pend, sc_emit, idle_scan;
  logic [5:0] p_type;
  res_t       pend_tok, sc_tok;
  logic [1:0] n_push, base;

  assign c     = in_chan.ch;
  assign acc   = in_chan.valid && in_chan.ready;
  assign pop   = (cnt_r != 2'd0) && out_chan.ready;
  assign endf  = in_chan.end_of_input || (c == 8'h00);
  assign a_c   = is_alpha(c);
  assign d_c   = is_digit(c);
  assign s_c   = is_space(c);
  assign col_c = (c == CH_COLON);
  assign dot_c = (c == CH_DOT);
  assign p_type = punct_type(c);

  assign in_chan.ready = (cnt_r <= 2'd1);

  always_comb begin
    cont = 1'b0;
    cc   = 1'b0;
    pend = 1'b0;
    case (mode_r)
      MODE_IDENT:  begin
        cont = !endf && (a_c || d_c || c == CH_UNDER);
        pend = !cont;
      end
      MODE_NUMBER: begin
        cont = !endf && (d_c || (dot_c && !seen_dot_r));
        pend = !cont;
      end
      MODE_COLON:  begin
        cc   = !endf && col_c;
        pend = !cc;
      end
      default: ;
    endcase
  end

  assign idle_scan = !cont && !cc;
  assign sc_emit   = cc || (idle_scan && (endf || !(s_c || a_c || d_c || col_c)));

  // byte counters, advanced by every byte that is not an end marker
  always_comb begin
    pos_nxt  = pos_r;
    line_nxt = line_r;
    col_nxt  = col_r;
    if (!endf) begin
      pos_nxt = pos_r + 1'b1;
      if (col_r != '1) col_nxt = col_r + 1'b1;
      if (c == CH_NEWLINE) begin
        if (line_r != '1) line_nxt = line_r + 1'b1;
        col_nxt = '0;
      end
    end
  end

  always_comb begin
    mode_nxt     = mode_r;
    seen_dot_nxt = seen_dot_r;
    prefix_nxt   = prefix_r;
    len_nxt      = len_r;
    ovf_nxt      = ovf_r;
    if (cont) begin
      if (dot_c) seen_dot_nxt = 1'b1;
      if (len_r < LEN_BITS'(LEN_LIMIT)) begin
        for (int i = 0; i < PREFIX_CHARS; i++) begin
          if (len_r == LEN_BITS'(i)) prefix_nxt[8*i +: 8] = c;
        end
        len_nxt = len_r + 1'b1;
      end else begin
        ovf_nxt = 1'b1;
      end
    end else begin
      mode_nxt = MODE_IDLE;
      if (idle_scan && !endf && (a_c || d_c)) begin
        mode_nxt     = a_c ? MODE_IDENT : MODE_NUMBER;
        seen_dot_nxt = 1'b0;
        prefix_nxt   = {40'd0, c};
        len_nxt      = LEN_BITS'(1);
        ovf_nxt      = 1'b0;
      end else if (idle_scan && !endf && col_c) begin
        mode_nxt = MODE_COLON;
      end
    end
  end

  always_comb begin
    pend_tok.token_type    = TT_COLON;
    pend_tok.token_length  = 6'd1;
    pend_tok.too_long      = 1'b0;
    if (mode_r == MODE_IDENT) begin
      pend_tok.token_type   = ident_type(prefix_r, len_r, ovf_r);
      pend_tok.token_length = 6'(len_r);
      pend_tok.too_long     = ovf_r;
    end else if (mode_r == MODE_NUMBER) begin
      pend_tok.token_type   = TT_NUMBER;
      pend_tok.token_length = 6'(len_r);
      pend_tok.too_long     = ovf_r;
    end
    pend_tok.end_position  = 32'(pos_r);
    pend_tok.line_number   = line_r;
    pend_tok.column_number = col_r;
    pend_tok.unknown_byte  = 8'd0;
    pend_tok.last_of_run   = !sc_emit;

    sc_tok.too_long      = 1'b0;
    sc_tok.last_of_run   = 1'b1;
    sc_tok.unknown_byte  = 8'd0;
    sc_tok.end_position  = 32'(pos_nxt);
    sc_tok.line_number   = line_nxt;
    sc_tok.column_number = col_nxt;
    if (cc) begin
      sc_tok.token_type   = TT_COLONCOLON;
      sc_tok.token_length = 6'd2;
    end else if (endf) begin
      sc_tok.token_type    = TT_EOF;
      sc_tok.token_length  = 6'd0;
      sc_tok.end_position  = '0;
      sc_tok.line_number   = '0;
      sc_tok.column_number = '0;
    end else begin
      sc_tok.token_type   = p_type;
      sc_tok.token_length = 6'd1;
      if (p_type == TT_UNKNOWN) sc_tok.unknown_byte = c;
    end
  end

  // output queue: shift on pop, then append this byte's words
  assign n_push = acc ? (2'(pend) + 2'(sc_emit)) : 2'd0;
  assign base   = cnt_r - 2'(pop);

  always_comb begin
    sh[0] = pop ? q_r[1] : q_r[0];
    sh[1] = pop ? q_r[2] : q_r[1];
    sh[2] = q_r[2];
    for (int i = 0; i < 3; i++) begin
      q_nxt[i] = sh[i];
      if (n_push != 2'd0 && base == 2'(i)) q_nxt[i] = pend ? pend_tok : sc_tok;
      if (n_push == 2'd2 && base + 2'd1 == 2'(i)) q_nxt[i] = sc_tok;
    end
    cnt_nxt = base + n_push;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= MODE_IDLE;
      seen_dot_r <= 1'b0;
      prefix_r   <= '0;
      len_r      <= '0;
      ovf_r      <= 1'b0;
      pos_r      <= '0;
      line_r     <= '0;
      col_r      <= '0;
      cnt_r      <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (acc) begin
        mode_r     <= mode_nxt;
        seen_dot_r <= seen_dot_nxt;
        prefix_r   <= prefix_nxt;
        len_r      <= len_nxt;
        ovf_r      <= ovf_nxt;
        pos_r      <= pos_nxt;
        line_r     <= line_nxt;
        col_r      <= col_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  assign out_chan.valid         = (cnt_r != 2'd0);
  assign out_chan.token_type    = q_r[0].token_type;
  assign out_chan.end_position  = q_r[0].end_position;
  assign out_chan.line_number   = q_r[0].line_number;
  assign out_chan.column_number = q_r[0].column_number;
  assign out_chan.token_length  = q_r[0].token_length;
  assign out_chan.unknown_byte  = q_r[0].unknown_byte;
  assign out_chan.too_long      = q_r[0].too_long;
  assign out_chan.last_of_run   = q_r[0].last_of_run;

  // a word that is not last of its run always has its partner queued behind it
  `SBT_ASSERT_SAME(a_pair_queued, (cnt_r != 2'd0) && !q_r[0].last_of_run, cnt_r >= 2'd2)
  `SBT_ASSERT_NEXT(a_eof_queued, acc && in_chan.end_of_input, cnt_r != 2'd0)
  `SBT_ASSERT_NEXT(a_eof_idle, acc && in_chan.end_of_input, mode_r == MODE_IDLE)
  `SBT_ASSERT_SAME(a_eof_zero_loc, (cnt_r != 2'd0) && q_r[0].token_type == TT_EOF,
                   q_r[0].end_position == 32'd0 && q_r[0].line_number == 24'd0 &&
                   q_r[0].column_number == 16'd0)

endmodule

// ----- tb/source_byte_tokenizer_tb.sv -----
// Self-checking testbench for source_byte_tokenizer: byte words in, token words out.
// Uses sbt_pkg and the sbt_in_if / sbt_out_if channels; a built-in scanner model
// predicts each token word, but for the table rows that carry their own expected word.
module source_byte_tokenizer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sbt_pkg::*;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_CYCLES = 20;
  localparam int RANDOM_BYTES = 1125;
  localparam int DIR_N        = 25;

  typedef enum {CK_SPACE, CK_LETTER, CK_DIGIT, CK_OTHER} char_kind_t;

  typedef struct packed {
    logic       eoi;
    logic [7:0] ch;
    logic       typed;
    res_t       want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  sbt_in_if  in_bus ();
  sbt_out_if out_bus ();

  source_byte_tokenizer dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_bus),
    .out_chan (out_bus)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  string kw_words [NUM_KW] = '{
    "i8", "i16", "i32", "i64", "u8", "u16", "u32", "u64", "f32", "f64",
    "bool", "void", "struct", "fn", "true", "false", "const", "return", "enum"
  };
  string punct_set = "=;{}(),+-*/&![].";
  string blank_set = " \t\n\v\f\r";

  // scanner state
  logic [1:0]  scan_st;
  bit          dot_seen;
  logic [47:0] head_bytes;
  int unsigned tok_len;
  bit          tok_ovf;
  logic [31:0] pos_cnt;
  logic [23:0] line_cnt;
  logic [15:0] col_cnt;

  res_t fresh [$];
  res_t pending_tokens [$];

  int  bytes_sent;
  int  tokens_checked;
  int  kw_hits;
  int  overlong_hits;
  int  mismatches;
  int  cycles;
  int  src_calm;
  logic [63:0] seen_types;

  dir_row_t dir_rows [DIR_N];

  function automatic char_kind_t kind_of(input logic [7:0] c);
    if (c == " " || (c >= 8'h09 && c <= 8'h0d)) return CK_SPACE;
    if ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z")) return CK_LETTER;
    if (c >= "0" && c <= "9") return CK_DIGIT;
    return CK_OTHER;
  endfunction

  function automatic void bump_counters(input logic [7:0] c);
    if (col_cnt != 16'hFFFF) col_cnt++;
    if (c == CH_NEWLINE) begin
      if (line_cnt != 24'hFFFFFF) line_cnt++;
      col_cnt = '0;
    end
    pos_cnt++;
  endfunction

  function automatic void add_char(input logic [7:0] c);
    if (tok_len < LEN_LIMIT) begin
      if (tok_len < PREFIX_CHARS) head_bytes[8*tok_len +: 8] = c;
      tok_len++;
    end else begin
      tok_ovf = 1'b1;
    end
  endfunction

  function automatic void open_token(input logic [1:0] mode, input logic [7:0] c);
    scan_st = mode;
    dot_seen = 1'b0;
    head_bytes = '0;
    tok_len = 0;
    tok_ovf = 1'b0;
    add_char(c);
  endfunction

  function automatic void push_token(input logic [5:0] tt, input int unsigned len,
                                     input logic [7:0] unk, input bit lng, input bit eof);
    res_t r;
    r.token_type    = tt;
    r.end_position  = eof ? '0 : pos_cnt;
    r.line_number   = eof ? '0 : line_cnt;
    r.column_number = eof ? '0 : col_cnt;
    r.token_length  = 6'(len);
    r.unknown_byte  = unk;
    r.too_long      = lng;
    r.last_of_run   = 1'b0;
    fresh.push_back(r);
  endfunction

  function automatic logic [5:0] keyword_code();
    bit hit;
    int k;
    int i;
    if (tok_ovf) return TT_IDENT;
    for (k = 0; k < NUM_KW; k++) begin
      if (kw_words[k].len() == int'(tok_len)) begin
        hit = 1'b1;
        for (i = 0; i < int'(tok_len); i++) begin
          if (head_bytes[8*i +: 8] != kw_words[k][i]) hit = 1'b0;
        end
        if (hit) return 6'(TT_KW_BASE + k);
      end
    end
    return TT_IDENT;
  endfunction

  function automatic logic [5:0] single_char_code(input logic [7:0] c);
    case (c)
      "=":     return TT_ASSIGN;
      ";":     return TT_SEMI;
      "{":     return TT_LBRACE;
      "}":     return TT_RBRACE;
      "(":     return TT_LPAREN;
      ")":     return TT_RPAREN;
      ",":     return TT_COMMA;
      "+":     return TT_PLUS;
      "-":     return TT_MINUS;
      "*":     return TT_STAR;
      "/":     return TT_SLASH;
      "&":     return TT_AMP;
      "!":     return TT_BANG;
      "[":     return TT_LBRACKET;
      "]":     return TT_RBRACKET;
      ".":     return TT_DOT;
      default: return TT_UNKNOWN;
    endcase
  endfunction

  // tokens caused by one byte word land in fresh
  function automatic void tokenize_byte(input logic [7:0] c, input logic eoi);
    bit is_end;
    bit done;
    char_kind_t ck;
    logic [5:0] tt;
    fresh.delete();
    is_end = eoi || c == 8'h00;
    ck = kind_of(c);
    done = 1'b0;
    case (scan_st)
      MODE_IDENT: begin
        if (!is_end && (ck == CK_LETTER || ck == CK_DIGIT || c == CH_UNDER)) begin
          add_char(c);
          bump_counters(c);
          done = 1'b1;
        end else begin
          push_token(keyword_code(), tok_len, 8'h00, tok_ovf, 1'b0);
          scan_st = MODE_IDLE;
        end
      end
      MODE_NUMBER: begin
        if (!is_end && (ck == CK_DIGIT || (c == CH_DOT && !dot_seen))) begin
          if (c == CH_DOT) dot_seen = 1'b1;
          add_char(c);
          bump_counters(c);
          done = 1'b1;
        end else begin
          push_token(TT_NUMBER, tok_len, 8'h00, tok_ovf, 1'b0);
          scan_st = MODE_IDLE;
        end
      end
      MODE_COLON: begin
        scan_st = MODE_IDLE;
        if (!is_end && c == CH_COLON) begin
          bump_counters(c);
          push_token(TT_COLONCOLON, 2, 8'h00, 1'b0, 1'b0);
          done = 1'b1;
        end else begin
          push_token(TT_COLON, 1, 8'h00, 1'b0, 1'b0);
        end
      end
      default: ;
    endcase
    if (!done) begin
      if (is_end) begin
        push_token(TT_EOF, 0, 8'h00, 1'b0, 1'b1);
      end else if (ck == CK_SPACE) begin
        bump_counters(c);
      end else if (ck == CK_LETTER) begin
        open_token(MODE_IDENT, c);
        bump_counters(c);
      end else if (ck == CK_DIGIT) begin
        open_token(MODE_NUMBER, c);
        bump_counters(c);
      end else if (c == CH_COLON) begin
        scan_st = MODE_COLON;
        bump_counters(c);
      end else begin
        tt = single_char_code(c);
        bump_counters(c);
        push_token(tt, 1, (tt == TT_UNKNOWN) ? c : 8'h00, 1'b0, 1'b0);
      end
    end
    if (fresh.size() > 0) fresh[fresh.size() - 1].last_of_run = 1'b1;
  endfunction

  function automatic res_t tok(input logic [5:0] tt, input int pos,
                               input int ln, input int col,
                               input int len, input logic [7:0] unk);
    return '{tt, 32'(pos), 24'(ln), 16'(col), 6'(len), unk, 1'b0, 1'b1};
  endfunction

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(11, 40);
  endfunction

  function automatic logic [7:0] letter();
    int r;
    r = $urandom_range(0, 51);
    return (r < 26) ? 8'("a" + r) : 8'("A" + r - 26);
  endfunction

  function automatic logic [7:0] digit_char();
    return 8'("0" + $urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] ident_char();
    int r;
    r = $urandom_range(0, 62);
    if (r < 52) return letter();
    if (r < 62) return digit_char();
    return CH_UNDER;
  endfunction

  function automatic int token_len();
    return ($urandom_range(0, 19) == 0) ? $urandom_range(58, 70) : $urandom_range(1, 8);
  endfunction

  task automatic send_word(input logic [7:0] c, input logic e = 1'b0,
                           input bit typed = 1'b0, input res_t typed_tok = '0);
    int gap;
    gap = 0;
    if (src_calm > 0) begin
      src_calm--;
    end else if ($urandom_range(0, 99) == 0) begin
      src_calm = $urandom_range(30, 150);
    end
    if (src_calm == 0 && $urandom_range(0, 99) < 40) gap = idle_len();
    if (gap > 0) begin
      in_bus.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_bus.valid = 1'b1;
    in_bus.ch = c;
    in_bus.end_of_input = e;
    do @(posedge clk); while (in_bus.ready !== 1'b1);
    tokenize_byte(c, e);
    if (typed) pending_tokens.push_back(typed_tok);
    else pending_tokens = {pending_tokens, fresh};
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_separator();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) send_word(blank_set[$urandom_range(0, 5)]);
    else if (r < 7) send_word(punct_set[$urandom_range(0, 15)]);
    else if (r == 7) send_word(CH_COLON);
  endtask

  // mostly well-formed tokens with random content, some noise and end markers
  task automatic send_random_piece();
    int kind;
    int n;
    int i;
    int k;
    int dot_at;
    logic [7:0] b;
    kind = $urandom_range(0, 99);
    if (kind < 20) begin
      k = $urandom_range(0, NUM_KW - 1);
      n = kw_words[k].len();
      for (i = 0; i < n; i++) begin
        b = kw_words[k][i];
        if (i == 0 && $urandom_range(0, 9) == 0) b = b - 8'h20;
        send_word(b);
      end
      if ($urandom_range(0, 3) == 0) send_word(ident_char());
      send_separator();
    end else if (kind < 40) begin
      n = token_len();
      send_word(letter());
      for (i = 1; i < n; i++) send_word(ident_char());
      send_separator();
    end else if (kind < 55) begin
      n = token_len();
      dot_at = $urandom_range(0, 1) ? $urandom_range(1, n) : 0;
      send_word(digit_char());
      for (i = 1; i < n; i++) send_word((i == dot_at) ? CH_DOT : digit_char());
      if ($urandom_range(0, 5) == 0) send_word(CH_DOT);
      send_separator();
    end else if (kind < 70) begin
      send_word(punct_set[$urandom_range(0, 15)]);
    end else if (kind < 78) begin
      n = $urandom_range(1, 3);
      repeat (n) send_word(CH_COLON);
    end else if (kind < 88) begin
      n = $urandom_range(1, 4);
      repeat (n) send_word(blank_set[$urandom_range(0, 5)]);
    end else if (kind < 96) begin
      send_word(8'($urandom_range(0, 255)));
    end else begin
      send_word(8'($urandom_range(0, 255)), 1'b1);
    end
  endtask

  task automatic flag_field(input string name, input logic [63:0] want,
                            input logic [63:0] got);
    $display("%0t ERROR token %0d %s: expected 0x%0h, got 0x%0h",
             $time, tokens_checked, name, want, got);
    mismatches++;
  endtask

  always @(posedge clk) begin : token_check
    res_t got;
    res_t want;
    if (rst_n && out_bus.valid === 1'b1 && out_bus.ready === 1'b1) begin
      got = {out_bus.token_type, out_bus.end_position, out_bus.line_number,
             out_bus.column_number, out_bus.token_length, out_bus.unknown_byte,
             out_bus.too_long, out_bus.last_of_run};
      if (pending_tokens.size() == 0) begin
        $display("%0t ERROR unexpected token word: expected none, got 0x%0h", $time, got);
        mismatches++;
      end else begin
        want = pending_tokens.pop_front();
        if (got.token_type !== want.token_type)
          flag_field("token_type", want.token_type, got.token_type);
        if (got.end_position !== want.end_position)
          flag_field("end_position", want.end_position, got.end_position);
        if (got.line_number !== want.line_number)
          flag_field("line_number", want.line_number, got.line_number);
        if (got.column_number !== want.column_number)
          flag_field("column_number", want.column_number, got.column_number);
        if (got.token_length !== want.token_length)
          flag_field("token_length", want.token_length, got.token_length);
        if (got.unknown_byte !== want.unknown_byte)
          flag_field("unknown_byte", want.unknown_byte, got.unknown_byte);
        if (got.too_long !== want.too_long)
          flag_field("too_long", want.too_long, got.too_long);
        if (got.last_of_run !== want.last_of_run)
          flag_field("last_of_run", want.last_of_run, got.last_of_run);
        seen_types[want.token_type] = 1'b1;
        if (want.token_type >= TT_KW_BASE && want.token_type < TT_ASSIGN) kw_hits++;
        if (want.too_long) overlong_hits++;
        tokens_checked++;
      end
    end
  end

  // sink side: random stalls with calm stretches
  initial begin : sink_side
    int hold;
    int calm;
    hold = 0;
    calm = 0;
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (calm > 0) calm--;
      else if ($urandom_range(0, 199) == 0) calm = $urandom_range(50, 300);
      if (hold > 0) begin
        hold--;
        out_bus.ready = 1'b0;
      end else if (calm == 0 && $urandom_range(0, 99) < 25) begin
        hold = idle_len() - 1;
        out_bus.ready = 1'b0;
      end else begin
        out_bus.ready = 1'b1;
      end
    end
  end

  initial begin : watchdog
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("%0t timeout after %0d cycles, %0d token words outstanding",
             $time, cycles, pending_tokens.size());
    $display("Simulation FAILED");
    $finish;
  end

  initial begin : stimulus
    int r;
    int target;
    in_bus.valid = 1'b0;
    in_bus.ch = 8'h00;
    in_bus.end_of_input = 1'b0;
    scan_st = MODE_IDLE;
    dot_seen = 1'b0;
    head_bytes = '0;
    tok_len = 0;
    tok_ovf = 1'b0;
    pos_cnt = '0;
    line_cnt = '0;
    col_cnt = '0;
    bytes_sent = 0;
    tokens_checked = 0;
    kw_hits = 0;
    overlong_hits = 0;
    mismatches = 0;
    src_calm = 0;
    seen_types = '0;

    dir_rows = '{
      '{1'b0, 8'h00,      1'b1, tok(TT_EOF, 0, 0, 0, 0, 8'h00)},
      '{1'b1, 8'hFF,      1'b1, tok(TT_EOF, 0, 0, 0, 0, 8'h00)},
      '{1'b0, 8'hFF,      1'b1, tok(TT_UNKNOWN, 1, 0, 1, 1, 8'hFF)},
      '{1'b0, 8'h80,      1'b1, tok(TT_UNKNOWN, 2, 0, 2, 1, 8'h80)},
      '{1'b0, CH_UNDER,   1'b1, tok(TT_UNKNOWN, 3, 0, 3, 1, CH_UNDER)},
      '{1'b0, CH_NEWLINE, 1'b0, '0},
      '{1'b0, "=",        1'b1, tok(TT_ASSIGN, 5, 1, 1, 1, 8'h00)},
      '{1'b0, "i",        1'b0, '0},
      '{1'b0, "8",        1'b0, '0},
      '{1'b0, CH_COLON,   1'b0, '0},
      '{1'b0, CH_COLON,   1'b0, '0},
      '{1'b0, CH_COLON,   1'b0, '0},
      '{1'b0, "{",        1'b0, '0},
      '{1'b0, "1",        1'b0, '0},
      '{1'b0, CH_DOT,     1'b0, '0},
      '{1'b0, "5",        1'b0, '0},
      '{1'b0, CH_DOT,     1'b0, '0},
      '{1'b0, 8'h09,      1'b0, '0},
      '{1'b0, "Z",        1'b0, '0},
      '{1'b0, CH_UNDER,   1'b0, '0},
      '{1'b0, "9",        1'b0, '0},
      '{1'b1, "q",        1'b0, '0},
      '{1'b0, CH_COLON,   1'b0, '0},
      '{1'b0, 8'h00,      1'b0, '0},
      '{1'b0, 8'h7F,      1'b0, '0}
    };

    repeat (12) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    for (r = 0; r < DIR_N; r++) begin
      send_word(dir_rows[r].ch, dir_rows[r].eoi, dir_rows[r].typed, dir_rows[r].want);
    end

    target = bytes_sent + RANDOM_BYTES;
    while (bytes_sent < target) send_random_piece();
    in_bus.valid = 1'b0;

    while (pending_tokens.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d byte words (table rows, then random source text); checked %0d tokens.",
             bytes_sent, tokens_checked);
    $display("Token types seen %0d of 41, keywords %0d, overlong %0d, mismatches %0d.",
             $countones(seen_types), kw_hits, overlong_hits, mismatches);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
